[rtl/cumulative_seq_reorder_tracker_assert.svh]
// Assertion macros for the cumulative sequence reorder tracker
`ifndef CUMULATIVE_SEQ_REORDER_TRACKER_ASSERT_SVH
`define CUMULATIVE_SEQ_REORDER_TRACKER_ASSERT_SVH

`ifndef SYNTH
`define CSRT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("csrt assertion failed");
`define CSRT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("csrt assertion failed");
`else
`define CSRT_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define CSRT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[rtl/csrt_pkg.sv]
// Shared constants and types for the cumulative sequence reorder tracker
package csrt_pkg;

    localparam int WINDOW_SIZE = 64;
    localparam int SLOT_W      = $clog2(WINDOW_SIZE);
    localparam int SEQ_W       = 32;
    localparam int ADV_W       = 7;
    localparam int OUT_W       = 2;

    typedef enum logic [OUT_W-1:0] {
        OUT_DUPLICATE = 2'd0,
        OUT_IN_ORDER  = 2'd1,
        OUT_EARLY     = 2'd2,
        OUT_DROPPED   = 2'd3
    } outcome_t;

    typedef struct packed {
        logic shift;
        logic set;
    } cell_ctl_t;

endpackage

[rtl/cumulative_seq_reorder_tracker.sv]
// An accepted item goes through the evaluate and act states to the done strobe;
// an in-order item with buffered early numbers walks, one cell shift per cycle.
// The block takes no new item while busy; a new item is taken in the done cycle.
// The walk over the cell chain, one place per cycle, advances the head.
// Reset: head is zero and every window cell clears at once; no sweep is needed.
// The receiver cannot stall: the done strobe shows for exactly one cycle.
module cumulative_seq_reorder_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [csrt_pkg::SEQ_W-1:0]    seq_number,
    output logic                          done,
    output logic [csrt_pkg::SEQ_W-1:0]    in_order_head,
    output logic [csrt_pkg::OUT_W-1:0]    outcome,
    output logic [csrt_pkg::ADV_W-1:0]    advanced_by
);
    import csrt_pkg::*;

    `include "cumulative_seq_reorder_tracker_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACT,
        ST_WALK
    } state_t;

    state_t               state_reg,   state_next;
    logic [SEQ_W-1:0]     head_reg,    head_next;
    logic [ADV_W-1:0]     adv_reg,     adv_next;
    outcome_t             outcome_reg, outcome_next;
    logic                 done_reg,    done_next;

    logic [SEQ_W-1:0]     seq_reg;
    logic [SLOT_W-1:0]    slot_reg,    slot_next;
    outcome_t             kind_reg,    kind_next;

    logic [SEQ_W-1:0]     seq_gap;
    logic [SEQ_W-1:0]     dist_m2;
    logic [WINDOW_SIZE-1:0] window;
    cell_ctl_t            ctl [WINDOW_SIZE];
    logic                 bit0;
    logic                 slot_bit;
    logic                 shift_en;
    logic                 set_en;

    // classify the held number against the head
    always_comb
    begin
        seq_gap   = seq_reg - head_reg;
        dist_m2   = seq_gap - SEQ_W'(2);
        slot_next = dist_m2[SLOT_W-1:0];
        priority if (seq_reg <= head_reg)
        begin
            kind_next = OUT_DUPLICATE;
        end
        else if (seq_gap == SEQ_W'(1))
        begin
            kind_next = OUT_IN_ORDER;
        end
        else if (dist_m2 < SEQ_W'(WINDOW_SIZE))
        begin
            kind_next = OUT_EARLY;
        end
        else
        begin
            kind_next = OUT_DROPPED;
        end
    end

    assign bit0     = window[0];
    assign slot_bit = window[slot_reg];
    assign shift_en = ((state_reg == ST_ACT) && (kind_reg == OUT_IN_ORDER))
                      || (state_reg == ST_WALK);
    assign set_en   = (state_reg == ST_ACT) && (kind_reg == OUT_EARLY) && !slot_bit;

    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        logic right_in;

        if (i == WINDOW_SIZE - 1)
        begin : g_last
            assign right_in = 1'b0;
        end
        else
        begin : g_inner
            assign right_in = window[i+1];
        end

        assign ctl[i].shift = shift_en;
        assign ctl[i].set   = set_en && (slot_reg == SLOT_W'(i));

        csrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[i]),
            .shift_in (right_in),
            .bit_out  (window[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        adv_next     = adv_reg;
        outcome_next = outcome_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                unique case (kind_reg)
                    OUT_IN_ORDER:
                    begin
                        head_next    = head_reg + (bit0 ? SEQ_W'(2) : SEQ_W'(1));
                        adv_next     = bit0 ? ADV_W'(2) : ADV_W'(1);
                        outcome_next = OUT_IN_ORDER;
                        if (bit0)
                        begin
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    OUT_EARLY:
                    begin
                        adv_next     = '0;
                        outcome_next = slot_bit ? OUT_DUPLICATE : OUT_EARLY;
                        state_next   = ST_IDLE;
                        done_next    = 1'b1;
                    end
                    OUT_DUPLICATE, OUT_DROPPED:
                    begin
                        adv_next     = '0;
                        outcome_next = kind_reg;
                        state_next   = ST_IDLE;
                        done_next    = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (bit0)
                begin
                    head_next = head_reg + SEQ_W'(1);
                    adv_next  = adv_reg + ADV_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            adv_reg     <= '0;
            outcome_reg <= OUT_DUPLICATE;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            adv_reg     <= adv_next;
            outcome_reg <= outcome_next;
            done_reg    <= done_next;
        end
    end

    // hold the item and its classification
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            seq_reg <= seq_number;
        end
        if (state_reg == ST_EVAL)
        begin
            slot_reg <= slot_next;
            kind_reg <= kind_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign in_order_head = head_reg;
    assign outcome       = outcome_reg;
    assign advanced_by   = adv_reg;

    `CSRT_ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `CSRT_ASSERT_SAME(a_adv_zero, clk, rst_n, done_reg && (outcome_reg != OUT_IN_ORDER), adv_reg == '0)
    `CSRT_ASSERT_NEXT(a_head_hold, clk, rst_n, (state_reg == ST_IDLE) || (state_reg == ST_EVAL), $stable(head_reg))
    `CSRT_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)

endmodule

[rtl/csrt_cell.sv]
// One window cell: holds the early flag of one sequence number slot
module csrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  csrt_pkg::cell_ctl_t ctl,
    input  logic               shift_in,
    output logic               bit_out
);
    import csrt_pkg::*;

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        priority if (ctl.shift)
        begin
            bit_next = shift_in;
        end
        else if (ctl.set)
        begin
            bit_next = 1'b1;
        end
        else
        begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign bit_out = bit_reg;

endmodule
